>>> rtl/hanorm_pkg.sv
// Shared types and constants of the axis range normalizer.
package hanorm_pkg;

  // Quotient bits resolved by the divider chain, one per cell.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_W = 16;

  localparam logic signed [16:0] K_S16_NEG = -17'sd32768;
  localparam logic signed [16:0] K_S16_POS = 17'sd32767;
  localparam logic signed [16:0] K_S16_SPAN = 17'sd65535;
  localparam logic signed [16:0] K_U8_SPAN = 17'sd255;

  localparam logic [32:0] QMAG_SPAN16 = 33'd65535;
  localparam logic [32:0] QMAG_SPAN8 = 33'd255;
  localparam logic [32:0] QMAG_POS16 = 33'd32767;
  localparam logic [32:0] INT16_MIN_MAG = 33'd32768;

  typedef enum logic [1:0] {
    OP_U2S16     = 2'd0,
    OP_U2S16_INV = 2'd1,
    OP_S2S16     = 2'd2,
    OP_U2U8      = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] raw_value;
    logic signed [15:0] logical_low;
    logic signed [15:0] logical_high;
  } hanorm_req_t;

  typedef struct packed {
    logic signed [15:0] scaled_value;
    logic signed [15:0] range_low;
    logic [14:0]        range_high;
    logic               error;
  } hanorm_res_t;

  // Per-item control that rides along with the quotient.
  typedef struct packed {
    op_e                op;
    logic               neg;
    logic               den_zero;
    logic               num_zero;
    logic               pass;
    logic signed [15:0] pass_val;
  } hanorm_ctl_t;

  // Word handed from cell to cell: partial remainder, numerator bits
  // shifting out on top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_STEPS-1:0] nq;
    logic [DIV_W-1:0]     den;
    hanorm_ctl_t          ctl;
  } hanorm_div_t;

endpackage

>>> rtl/hanorm_front.sv
// Front end: operand selection, scaling product and magnitude split.
module hanorm_front import hanorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  hanorm_req_t req_i,
  output logic        valid_o,
  output hanorm_div_t div_o
);

  logic signed [16:0] val_w, lo_w, hi_w, n_w, w_w;
  logic signed [16:0] a_d, k_d, den_d;
  hanorm_ctl_t        ctl_d;

  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [16:0] s1_a_q, s1_k_q, s1_den_q, s2_den_q;
  hanorm_ctl_t        s1_ctl_q, s2_ctl_q;
  logic signed [33:0] prod_w, s2_prod_q, prod_abs_w;
  logic signed [16:0] den_abs_w;
  hanorm_div_t        div_d, div_q;

  always_comb begin
    val_w = 17'(req_i.raw_value);
    lo_w  = 17'(req_i.logical_low);
    hi_w  = 17'(req_i.logical_high);
    n_w   = val_w - lo_w;
    w_w   = hi_w - lo_w;

    ctl_d          = '0;
    ctl_d.op       = req_i.op;
    ctl_d.pass_val = req_i.raw_value;

    if (req_i.op == OP_S2S16) begin
      if (val_w < 0) begin
        a_d   = val_w;
        k_d   = K_S16_NEG;
        den_d = lo_w;
      end else if (val_w > 0) begin
        a_d   = val_w;
        k_d   = K_S16_POS;
        den_d = hi_w;
      end else begin
        // A zero reading is divided as zero by one, so it must not flag.
        a_d   = '0;
        k_d   = '0;
        den_d = 17'sd1;
      end
    end else begin
      ctl_d.pass = (lo_w == 0) && (hi_w == 0);
      a_d        = n_w;
      k_d        = (req_i.op == OP_U2U8) ? K_U8_SPAN : K_S16_SPAN;
      den_d      = w_w;
    end
  end

  assign prod_w     = s1_a_q * s1_k_q;
  assign prod_abs_w = (s2_prod_q < 0) ? -s2_prod_q : s2_prod_q;
  assign den_abs_w  = (s2_den_q < 0) ? -s2_den_q : s2_den_q;

  always_comb begin
    div_d              = '0;
    div_d.nq           = prod_abs_w[DIV_STEPS-1:0];
    div_d.den          = den_abs_w[DIV_W-1:0];
    div_d.ctl          = s2_ctl_q;
    div_d.ctl.neg      = (s2_prod_q < 0) != (s2_den_q < 0);
    div_d.ctl.den_zero = (s2_den_q == 0);
    div_d.ctl.num_zero = (s2_prod_q == 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q    <= a_d;
    s1_k_q    <= k_d;
    s1_den_q  <= den_d;
    s1_ctl_q  <= ctl_d;
    s2_prod_q <= prod_w;
    s2_den_q  <= s1_den_q;
    s2_ctl_q  <= s1_ctl_q;
    div_q     <= div_d;
  end

  assign valid_o = s3_valid_q;
  assign div_o   = div_q;

endmodule

>>> rtl/hanorm_div_cell.sv
// One restoring-division cell: resolves a single quotient bit per cycle.
module hanorm_div_cell import hanorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  hanorm_div_t div_i,
  output logic        valid_o,
  output hanorm_div_t div_o
);

  logic [DIV_W:0] trial_w, diff_w;
  logic           ge_w;
  hanorm_div_t    div_d, div_q;
  logic           valid_q;

  always_comb begin
    trial_w   = {div_i.rem, div_i.nq[DIV_STEPS-1]};
    diff_w    = trial_w - {1'b0, div_i.den};
    ge_w      = (trial_w >= {1'b0, div_i.den});
    div_d     = div_i;
    div_d.rem = ge_w ? diff_w[DIV_W-1:0] : trial_w[DIV_W-1:0];
    div_d.nq  = {div_i.nq[DIV_STEPS-2:0], ge_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

>>> rtl/hanorm_back.sv
// Back end: round half to even, saturate and map into the target range, or pass the reading through.
module hanorm_back import hanorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  hanorm_div_t div_i,
  output logic        done_o,
  output hanorm_res_t res_o
);

  logic [DIV_W:0] twice_rem_w, den_w;
  logic           round_up_w;
  logic [32:0]    qmag_d, qmag_q;
  hanorm_ctl_t    ctl_q;
  logic           r_valid_q, done_q;
  logic [32:0]    span_w;
  logic [15:0]    d_w;
  logic           sat_w;
  hanorm_res_t    res_d, res_q;

  always_comb begin
    twice_rem_w = {div_i.rem, 1'b0};
    den_w       = {1'b0, div_i.den};
    round_up_w  = (twice_rem_w > den_w) || ((twice_rem_w == den_w) && div_i.nq[0]);
    qmag_d      = {1'b0, div_i.nq} + 33'(round_up_w);
    // A zero divisor yields zero for a zero numerator and saturates otherwise.
    if (div_i.ctl.den_zero) begin
      qmag_d = div_i.ctl.num_zero ? '0 : '1;
    end
  end

  always_comb begin
    res_d  = '0;
    sat_w  = 1'b0;
    d_w    = '0;
    span_w = (ctl_q.op == OP_U2U8) ? QMAG_SPAN8 : QMAG_SPAN16;

    if (ctl_q.op == OP_S2S16) begin
      if (ctl_q.neg) begin
        if (qmag_q > INT16_MIN_MAG) begin
          sat_w = 1'b1;
          d_w   = 16'h8000;
        end else begin
          d_w = 16'(33'd0 - qmag_q);
        end
      end else begin
        if (qmag_q > QMAG_POS16) begin
          sat_w = 1'b1;
          d_w   = 16'h7fff;
        end else begin
          d_w = qmag_q[15:0];
        end
      end
    end else begin
      if (ctl_q.neg && (qmag_q != 0)) begin
        sat_w = 1'b1;
        d_w   = '0;
      end else if (qmag_q > span_w) begin
        sat_w = 1'b1;
        d_w   = span_w[15:0];
      end else begin
        d_w = qmag_q[15:0];
      end
    end

    case (ctl_q.op)
      OP_U2S16: begin
        res_d.scaled_value = d_w - 16'h8000;
        res_d.range_low    = -16'sd32768;
        res_d.range_high   = 15'h7fff;
      end
      OP_U2S16_INV: begin
        res_d.scaled_value = 16'h7fff - d_w;
        res_d.range_low    = -16'sd32768;
        res_d.range_high   = 15'h7fff;
      end
      OP_S2S16: begin
        res_d.scaled_value = d_w;
        res_d.range_low    = -16'sd32768;
        res_d.range_high   = 15'h7fff;
      end
      OP_U2U8: begin
        res_d.scaled_value = d_w;
        res_d.range_low    = '0;
        res_d.range_high   = 15'(QMAG_SPAN8);
      end
      default: begin
        res_d.scaled_value = d_w;
      end
    endcase
    res_d.error = sat_w || ctl_q.den_zero;

    // A zero range in the unsigned modes hands the reading through untouched.
    if (ctl_q.pass) begin
      res_d.scaled_value = ctl_q.pass_val;
      res_d.range_low    = '0;
      res_d.range_high   = '0;
      res_d.error        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      r_valid_q <= valid_i;
      done_q    <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qmag_q <= qmag_d;
    ctl_q  <= div_i.ctl;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/hid_axis_range_normalizer_unit.sv
// Top level of the axis range normalizer: front end, divider cell row, back end.
//
// The unit rescales one controller axis reading into a signed 16-bit or an
// unsigned 8-bit range with exact round-half-to-even division. It takes a new
// word in every cycle (busy is always low) and returns each result on res_o
// for exactly one cycle, marked by done_o, after the word has passed through
// three front stages, one cell per quotient bit in the row of 32 divider
// cells, and two stages for rounding and saturation. The receiver cannot hold
// results off, so done_o must be taken when it is shown.
module hid_axis_range_normalizer_unit import hanorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  hanorm_req_t req_i,
  output logic        done_o,
  output hanorm_res_t res_o
);

  logic        valid_w [0:DIV_STEPS];
  hanorm_div_t div_w   [0:DIV_STEPS];

  assign busy = 1'b0;

  hanorm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .req_i   (req_i),
    .valid_o (valid_w[0]),
    .div_o   (div_w[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    hanorm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .div_i   (div_w[i]),
      .valid_o (valid_w[i+1]),
      .div_o   (div_w[i+1])
    );
  end

  hanorm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[DIV_STEPS]),
    .div_i   (div_w[DIV_STEPS]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

>>> verif/hanorm_checker.sv
// Scoreboard for the axis range normalizer: predicts each result and compares it.
module hanorm_checker import hanorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  hanorm_req_t req_i,
  input  logic        done_o,
  input  hanorm_res_t res_o,
  output int          fail_cnt,
  output int          pending_cnt,
  output int          checked_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // Stand-in for an unbounded quotient after a division by zero.
  localparam longint HUGE_QUOT = longint'(1) << 40;

  hanorm_res_t scaled_q[$];
  int n_bad;
  int n_checked;

  function automatic longint div_half_even(longint num, longint den, inout bit err);
    longint an, ad, q, r;
    bit neg;
    if (den == 0) begin
      err = 1'b1;
      if (num == 0) return 0;
      return (num > 0) ? HUGE_QUOT : -HUGE_QUOT;
    end
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    r = an % ad;
    if (2 * r > ad || (2 * r == ad && (q % 2) == 1)) q++;
    return neg ? -q : q;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi, inout bit err);
    if (v < lo) begin
      err = 1'b1;
      return lo;
    end
    if (v > hi) begin
      err = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic hanorm_res_t axis_rescale(hanorm_req_t rq);
    longint val, lo, hi, n, span, d, res, rlo, rhi;
    bit err;
    hanorm_res_t r;
    val = rq.raw_value;
    lo = rq.logical_low;
    hi = rq.logical_high;
    err = 1'b0;
    if (rq.op == OP_S2S16) begin
      // Each sign of the reading is scaled against its own limit.
      res = 0;
      if (val < 0) res = div_half_even(val * -32768, lo, err);
      else if (val > 0) res = div_half_even(val * 32767, hi, err);
      res = clamp_to(res, -32768, 32767, err);
      rlo = -32768;
      rhi = 32767;
    end else if (lo == 0 && hi == 0) begin
      res = val;
      rlo = 0;
      rhi = 0;
    end else begin
      n = val - lo;
      span = hi - lo;
      if (rq.op == OP_U2U8) begin
        res = div_half_even(n * 255, span, err);
        res = clamp_to(res, 0, 255, err);
        rlo = 0;
        rhi = 255;
      end else begin
        d = div_half_even(n * 65535, span, err);
        d = clamp_to(d, 0, 65535, err);
        res = (rq.op == OP_U2S16_INV) ? 32767 - d : d - 32768;
        rlo = -32768;
        rhi = 32767;
      end
    end
    r.scaled_value = res[15:0];
    r.range_low = rlo[15:0];
    r.range_high = rhi[14:0];
    r.error = err;
    return r;
  endfunction

  always @(posedge clk_i) begin
    hanorm_res_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        if (scaled_q.size() == 0) begin
          $error("result word with no word outstanding: scaled_value %0d", res_o.scaled_value);
          n_bad++;
        end else begin
          exp_r = scaled_q.pop_front();
          n_checked++;
          if (res_o.scaled_value !== exp_r.scaled_value) begin
            $error("scaled_value: expected %0d, got %0d", exp_r.scaled_value, res_o.scaled_value);
            n_bad++;
          end
          if (res_o.range_low !== exp_r.range_low) begin
            $error("range_low: expected %0d, got %0d", exp_r.range_low, res_o.range_low);
            n_bad++;
          end
          if (res_o.range_high !== exp_r.range_high) begin
            $error("range_high: expected %0d, got %0d", exp_r.range_high, res_o.range_high);
            n_bad++;
          end
          if (res_o.error !== exp_r.error) begin
            $error("error: expected %0b, got %0b", exp_r.error, res_o.error);
            n_bad++;
          end
        end
      end
      if (start && !busy) scaled_q.push_back(axis_rescale(req_i));
    end
    fail_cnt <= n_bad;
    pending_cnt <= scaled_q.size();
    checked_cnt <= n_checked;
  end

endmodule

>>> verif/tb_hid_axis_range_normalizer_unit.sv
// Testbench top of the axis range normalizer: clock, reset, stimulus and verdict.
module tb_hid_axis_range_normalizer_unit import hanorm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  hanorm_req_t req_i;
  logic        done_o;
  hanorm_res_t res_o;
  int          fail_cnt;
  int          pending_cnt;
  int          checked_cnt;
  int          op_count[4];

  hid_axis_range_normalizer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  hanorm_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[hid_axis_range_normalizer_unit] ERROR");
    $finish;
  end

  // Presents one word and holds it until the unit takes it.
  task automatic send_word(hanorm_req_t w);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= w;
    op_count[w.op]++;
    do @(posedge clk_i); while (busy);
  endtask

  // Leaves start low with fresh junk on the request bus; the argument sets the gap.
  task automatic idle_cycles(int n);
    logic [63:0] rnd;
    logic [$bits(hanorm_req_t)-1:0] junk;
    repeat (n) begin
      rnd = {$urandom, $urandom};
      junk = rnd[$bits(hanorm_req_t)-1:0];
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= junk;
    end
  endtask

  function automatic int pick_gap(bit no_idle);
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    hanorm_req_t directed_q[$];
    hanorm_req_t w;
    int kind, shape, lo, hi, val;

    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full-scale endpoints in every unsigned mode.
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sh8000, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sh7fff, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_U2S16_INV, 16'sh8000, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_U2S16_INV, 16'sh7fff, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sd0, 16'sd0, 16'sd255});
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sd255, 16'sd0, 16'sd255});
    // Zero range passes the reading through.
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sh8000, 16'sd0, 16'sd0});
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sh7fff, 16'sd0, 16'sd0});
    // Zero width with and without a zero numerator.
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sd9, 16'sd5, 16'sd5});
    directed_q.push_back(hanorm_req_t'{OP_U2S16_INV, 16'sd5, 16'sd5, 16'sd5});
    // Saturation on both sides of the 8-bit range.
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sd300, 16'sd0, 16'sd255});
    directed_q.push_back(hanorm_req_t'{OP_U2U8, -16'sd5, 16'sd0, 16'sd255});
    // Exact halves: two round up to even, one down to even.
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sd1, 16'sd0, 16'sd2});
    directed_q.push_back(hanorm_req_t'{OP_U2U8, 16'sd1, 16'sd0, 16'sd6});
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sd1, 16'sd0, 16'sd2});
    // Signed mode: extremes, zero, zero limits, inverted limits.
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sh8000, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sh7fff, 16'sh8000, 16'sh7fff});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sd0, 16'sd0, 16'sd0});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, -16'sd1, 16'sd0, 16'sd10});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sd1, -16'sd10, 16'sd0});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, -16'sd100, 16'sd100, -16'sd100});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sd100, 16'sd100, -16'sd100});
    directed_q.push_back(hanorm_req_t'{OP_S2S16, 16'sh8000, -16'sd1, 16'sd1});
    // Reversed limits in the unsigned modes.
    directed_q.push_back(hanorm_req_t'{OP_U2S16, 16'sd0, 16'sd100, -16'sd100});
    directed_q.push_back(hanorm_req_t'{OP_U2S16_INV, 16'sh8000, 16'sh7fff, 16'sh8000});

    foreach (directed_q[i]) begin
      send_word(directed_q[i]);
      idle_cycles(pick_gap(1'b0));
    end

    for (int i = 0; i < 800; i++) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = int'($urandom_range(65535)) - 32768;
        val = int'($urandom_range(65535)) - 32768;
      end else begin
        shape = $urandom_range(9);
        case (shape)
          0, 1: begin
            lo = -32768;
            hi = 32767;
          end
          2, 3: begin
            lo = 0;
            hi = $urandom_range(32767, 1);
          end
          4, 5: begin
            lo = -int'($urandom_range(32768, 1));
            hi = $urandom_range(32767, 1);
          end
          6: begin
            lo = 0;
            hi = 0;
          end
          7: begin
            // Narrow ranges make exact halves and zero widths common.
            lo = int'($urandom_range(200)) - 100;
            hi = lo + int'($urandom_range(6));
          end
          8: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = int'($urandom_range(65535)) - 32768;
          end
          default: begin
            lo = $urandom_range(32767, 1);
            hi = -int'($urandom_range(32768, 1));
          end
        endcase
        if ($urandom_range(4) == 0) val = int'($urandom_range(65535)) - 32768;
        else if (hi >= lo) val = lo + int'($urandom_range(hi - lo));
        else val = hi + int'($urandom_range(lo - hi));
      end
      w.op = op_e'($urandom_range(3));
      w.raw_value = val[15:0];
      w.logical_low = lo[15:0];
      w.logical_high = hi[15:0];
      send_word(w);
      // Every third block of 100 words runs back to back.
      idle_cycles(pick_gap((i / 100) % 3 == 1));
    end

    idle_cycles(1);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);

    $display("Sent %0d words (modes 0..3: %0d/%0d/%0d/%0d), %0d results compared.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3], checked_cnt);
    $display("Covered full-scale, zero-range, zero-width, tie, saturated and reversed limits.");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[hid_axis_range_normalizer_unit] OK");
    end else begin
      $display("[hid_axis_range_normalizer_unit] ERROR");
    end
    $finish;
  end

endmodule
